FILE: src/ssu_pkg.sv
// Shared constants, types and helpers for the sine series unit.
// Holds the item record that travels down the pipeline and the reciprocal table.
// No dependencies.
`default_nettype none

package ssu_pkg;

  localparam int MAX_TERMS = 12;
  localparam int CNT_W     = $clog2(MAX_TERMS + 1);
  localparam int ANGLE_W   = 32;
  localparam int ABS_W     = 30;
  localparam int SQ_W      = 32;
  localparam int TERM_W    = 33;
  localparam int RECIP_W   = 32;
  localparam int SUM_W     = 38;
  localparam int SINE_W    = 32;
  localparam int TC_W      = 4;

  localparam logic signed [ANGLE_W-1:0] PI_Q28  = 32'sd843314857;
  localparam logic signed [SUM_W-1:0]   ONE_Q30 = 38'sd1073741824;

  typedef struct packed {
    logic [CNT_W-1:0]        n;
    logic                    neg;
    logic                    clamped;
    logic [SQ_W-1:0]         sq;
    logic [TERM_W-1:0]       t;
    logic signed [SUM_W-1:0] sum;
  } ssu_item_t;

  // Q32 reciprocal of (2k+2)(2k+3), rounded to nearest.
  function automatic logic [RECIP_W-1:0] ssu_recip(input logic [CNT_W-1:0] k);
    logic [RECIP_W-1:0] r;
    case (int'(k))
      0:       r = 32'd715827883;
      1:       r = 32'd214748365;
      2:       r = 32'd102261126;
      3:       r = 32'd59652324;
      4:       r = 32'd39045157;
      5:       r = 32'd27531842;
      6:       r = 32'd20452225;
      7:       r = 32'd15790321;
      8:       r = 32'd12558384;
      9:       r = 32'd10226113;
      10:      r = 32'd8488078;
      11:      r = 32'd7158279;
      12:      r = 32'd6118187;
      13:      r = 32'd5289369;
      14:      r = 32'd4618244;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Adds term k of the series to the running sum when k lies below the term count.
  function automatic logic signed [SUM_W-1:0] ssu_acc(
    input logic signed [SUM_W-1:0] sum,
    input logic [TERM_W-1:0]       t,
    input logic                    neg,
    input logic [CNT_W-1:0]        k,
    input logic [CNT_W-1:0]        n
  );
    logic signed [SUM_W-1:0] ext;
    logic                    minus;
    ext   = signed'({{(SUM_W-TERM_W){1'b0}}, t});
    minus = neg ^ k[0];
    if (k >= n) begin
      return sum;
    end
    return minus ? sum - ext : sum + ext;
  endfunction

endpackage

`default_nettype wire

FILE: src/ssu_term_step.sv
// One step of the series recurrence: two register stages that form the next
// term from the current one and add the current term to the sum.
// Depends on ssu_pkg.
`default_nettype none

module ssu_term_step (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic [ssu_pkg::CNT_W-1:0] k,
  input  wire logic                     up_valid,
  input  wire ssu_pkg::ssu_item_t       up_item,
  output logic                          up_go,
  input  wire logic                     dn_go,
  output logic                          dn_valid,
  output ssu_pkg::ssu_item_t            dn_item
);
  import ssu_pkg::*;

  logic                        v1_r, v2_r;
  ssu_item_t                   item1_r, item1_nxt;
  ssu_item_t                   item2_r, item2_nxt;
  logic                        go1, go2;
  logic [TERM_W+RECIP_W-1:0]   prod1;
  logic [TERM_W+SQ_W-1:0]      prod2;

  assign go2   = ~v2_r | dn_go;
  assign go1   = ~v1_r | go2;
  assign up_go = go1;

  always_comb begin
    prod1     = {{RECIP_W{1'b0}}, up_item.t} * {{TERM_W{1'b0}}, ssu_recip(k)};
    item1_nxt = up_item;
    item1_nxt.t   = prod1[RECIP_W +: TERM_W];
    item1_nxt.sum = ssu_acc(up_item.sum, up_item.t, up_item.neg, k, up_item.n);
  end

  always_comb begin
    prod2     = {{SQ_W{1'b0}}, item1_r.t} * {{TERM_W{1'b0}}, item1_r.sq};
    item2_nxt = item1_r;
    item2_nxt.t = prod2[28 +: TERM_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (go1) begin
        v1_r <= up_valid;
      end
      if (go2) begin
        v2_r <= v1_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go1) begin
      item1_r <= item1_nxt;
    end
    if (go2) begin
      item2_r <= item2_nxt;
    end
  end

  assign dn_valid = v2_r;
  assign dn_item  = item2_r;

endmodule

`default_nettype wire

FILE: src/sine_series_unit.sv
// Top level of the sine series unit: clamp, square, term pipeline and saturation.
// Depends on ssu_pkg and ssu_term_step.
//
// The unit takes an angle in radians (signed Q3.28) and returns its sine
// (signed Q1.30) as the sum of up to twelve Maclaurin terms; angles beyond
// plus or minus pi are clamped and flagged. One request is accepted every
// clock cycle while the output is not stalled. Each request passes through
// one entry stage, one squaring stage, two multiplier stages per term step
// and the output stage. A stalled output holds only the stages that are
// full, so empty stages keep taking requests.
// The term count should be written only while the unit is empty.
`default_nettype none

module sine_series_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wr_en,
  input  wire logic [ssu_pkg::TC_W-1:0]      cfg_wr_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [ssu_pkg::ANGLE_W-1:0] in_angle,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [ssu_pkg::SINE_W-1:0]  out_sine,
  output logic                               out_clamped
);
  import ssu_pkg::*;

  logic [TC_W-1:0]          term_count_r;
  logic                     va_r, vb_r, vo_r;
  ssu_item_t                itema_r, itema_nxt;
  ssu_item_t                itemb_r, itemb_nxt;
  logic signed [SUM_W-1:0]  sum_r, sum_nxt;
  logic                     clamped_r;
  logic                     go_a, go_b, go_o;
  logic signed [ANGLE_W-1:0] x;
  logic [ABS_W-1:0]         a_abs, b_abs;
  logic [2*ABS_W-1:0]       sq_full;
  logic signed [SUM_W-1:0]  fin;

  ssu_item_t                chain_item [MAX_TERMS];
  logic                     chain_v    [MAX_TERMS];
  logic                     chain_go   [MAX_TERMS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      term_count_r <= TC_W'(12);
    end else if (cfg_wr_en) begin
      term_count_r <= cfg_wr_data;
    end
  end

  assign go_o     = ~vo_r | out_ready;
  assign go_b     = ~vb_r | chain_go[0];
  assign go_a     = ~va_r | go_b;
  assign in_ready = go_a;

  always_comb begin
    itema_nxt         = '0;
    itema_nxt.clamped = 1'b0;
    x                 = in_angle;
    if (in_angle > PI_Q28) begin
      x                 = PI_Q28;
      itema_nxt.clamped = 1'b1;
    end else if (in_angle < -PI_Q28) begin
      x                 = -PI_Q28;
      itema_nxt.clamped = 1'b1;
    end
    itema_nxt.neg = x[ANGLE_W-1];
    a_abs         = x[ANGLE_W-1] ? ABS_W'(-x) : ABS_W'(x);
    itema_nxt.t   = {1'b0, a_abs, 2'b00};
    if (term_count_r == '0) begin
      itema_nxt.n = CNT_W'(1);
    end else if (int'(term_count_r) > MAX_TERMS) begin
      itema_nxt.n = CNT_W'(MAX_TERMS);
    end else begin
      itema_nxt.n = CNT_W'(term_count_r);
    end
  end

  always_comb begin
    b_abs        = itema_r.t[ABS_W+1:2];
    sq_full      = {{ABS_W{1'b0}}, b_abs} * {{ABS_W{1'b0}}, b_abs};
    itemb_nxt    = itema_r;
    itemb_nxt.sq = sq_full[28 +: SQ_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (go_a) begin
        va_r <= in_valid;
      end
      if (go_b) begin
        vb_r <= va_r;
      end
      if (go_o) begin
        vo_r <= chain_v[MAX_TERMS-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go_a) begin
      itema_r <= itema_nxt;
    end
    if (go_b) begin
      itemb_r <= itemb_nxt;
    end
    if (go_o) begin
      sum_r     <= sum_nxt;
      clamped_r <= chain_item[MAX_TERMS-1].clamped;
    end
  end

  assign chain_item[0]         = itemb_r;
  assign chain_v[0]            = vb_r;
  assign chain_go[MAX_TERMS-1] = go_o;

  for (genvar i = 0; i < MAX_TERMS - 1; i++) begin : g_step
    ssu_term_step u_step (
      .clk      (clk),
      .rst_n    (rst_n),
      .k        (CNT_W'(i)),
      .up_valid (chain_v[i]),
      .up_item  (chain_item[i]),
      .up_go    (chain_go[i]),
      .dn_go    (chain_go[i+1]),
      .dn_valid (chain_v[i+1]),
      .dn_item  (chain_item[i+1])
    );
  end

  always_comb begin
    fin = ssu_acc(chain_item[MAX_TERMS-1].sum, chain_item[MAX_TERMS-1].t,
                  chain_item[MAX_TERMS-1].neg, CNT_W'(MAX_TERMS - 1),
                  chain_item[MAX_TERMS-1].n);
    if (fin > ONE_Q30) begin
      sum_nxt = ONE_Q30;
    end else if (fin < -ONE_Q30) begin
      sum_nxt = -ONE_Q30;
    end else begin
      sum_nxt = fin;
    end
  end

  assign out_valid   = vo_r;
  assign out_sine    = sum_r[SINE_W-1:0];
  assign out_clamped = clamped_r;

endmodule

`default_nettype wire

FILE: tb/tb_sine_series_unit.sv
// Testbench for sine_series_unit: directed, term-sweep and random requests; random stalls outside steady phases.
// Each result is checked against a fixed-point series predictor kept in this file.
// Depends on ssu_pkg and the sine_series_unit RTL.
`timescale 1ns / 1ps

module tb_sine_series_unit;
  import ssu_pkg::*;

  typedef struct packed {
    logic signed [SINE_W-1:0] sine;
    logic                     clamped;
  } sine_result_t;

  localparam int DRAIN_CYCLES = 2 * MAX_TERMS + 8;

  logic                      clk;
  logic                      rst_n = 1'b0;
  logic                      cfg_wr_en = 1'b0;
  logic [TC_W-1:0]           cfg_wr_data = '0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic signed [ANGLE_W-1:0] in_angle = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic signed [SINE_W-1:0]  out_sine;
  logic                      out_clamped;

  sine_result_t pending_sines[$];
  logic [TC_W-1:0] terms_reg = 4'd12;
  bit steady = 1'b0;
  int mismatches = 0;

  sine_series_unit u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_angle    (in_angle),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_sine    (out_sine),
    .out_clamped (out_clamped)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb_sine_series_unit: FAIL");
    $finish;
  end

  function automatic sine_result_t predict_sine(input logic signed [ANGLE_W-1:0] angle);
    longint x;
    longint unsigned mag;
    longint unsigned sq;
    longint unsigned term;
    longint unsigned den;
    longint unsigned recip;
    longint acc;
    int terms;
    bit minus;
    sine_result_t r;
    x = angle;
    r.clamped = 1'b0;
    if (x > longint'(PI_Q28)) begin
      x = PI_Q28;
      r.clamped = 1'b1;
    end else if (x < -longint'(PI_Q28)) begin
      x = -longint'(PI_Q28);
      r.clamped = 1'b1;
    end
    mag = (x < 0) ? longint'(-x) : longint'(x);
    sq = (mag * mag) >> 28;
    term = mag << 2;
    terms = terms_reg;
    if (terms < 1) terms = 1;
    if (terms > MAX_TERMS) terms = MAX_TERMS;
    acc = 0;
    for (int k = 0; k < terms; k++) begin
      minus = (x < 0) ^ (k % 2 == 1);
      acc = minus ? acc - longint'(term) : acc + longint'(term);
      if (k + 1 < terms) begin
        den = (2 * k + 2) * (2 * k + 3);
        recip = ((64'd1 << 32) + den / 2) / den;
        term = (term * recip) >> 32;
        term = (term * sq) >> 28;
      end
    end
    if (acc > longint'(ONE_Q30)) acc = ONE_Q30;
    if (acc < -longint'(ONE_Q30)) acc = -longint'(ONE_Q30);
    r.sine = acc[SINE_W-1:0];
    return r;
  endfunction

  // Called at a rising edge; returns at the edge where the request is taken.
  task automatic send_angle(input logic signed [ANGLE_W-1:0] angle);
    int gap;
    bit taken;
    gap = steady ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_angle <= angle;
    do begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end while (!taken);
    pending_sines.push_back(predict_sine(angle));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_sines.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_terms(input logic [TC_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    terms_reg = value;
    @(posedge clk);
  endtask

  function automatic logic signed [ANGLE_W-1:0] random_angle();
    logic signed [ANGLE_W-1:0] a;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: a = int'($urandom_range(0, 2 * PI_Q28)) - PI_Q28;
      6: a = int'($urandom_range(0, 4095)) - 2048;
      7: begin
        a = PI_Q28 + int'($urandom_range(0, 8)) - 4;
        if ($urandom_range(0, 1)) a = -a;
      end
      default: a = $urandom;
    endcase
    return a;
  endfunction

  task automatic test_directed();
    logic signed [ANGLE_W-1:0] angles[$];
    angles = '{32'sd0, 32'sd1, -32'sd1, 32'sd268435456, -32'sd268435456,
               32'sd421657428, -32'sd421657428, PI_Q28, -PI_Q28, PI_Q28 + 1,
               -PI_Q28 - 1, PI_Q28 - 1, -PI_Q28 + 1, 32'sh7fffffff,
               32'sh80000000, 32'sh55555555, 32'shaaaaaaaa, 32'sd632486143};
    foreach (angles[i]) send_angle(angles[i]);
    wait_idle();
  endtask

  task automatic test_term_sweep();
    for (int tc = 0; tc < 16; tc++) begin
      set_terms(TC_W'(tc));
      send_angle(PI_Q28);
      send_angle(-32'sd421657428);
      send_angle(random_angle());
      wait_idle();
    end
  endtask

  task automatic test_random_phases();
    logic [TC_W-1:0] phase_terms[8];
    phase_terms = '{4'd12, 4'd1, 4'd15, 4'd0, 4'd6, 4'd12, 4'd3, 4'd9};
    foreach (phase_terms[p]) begin
      set_terms((p == 7) ? TC_W'($urandom_range(0, 15)) : phase_terms[p]);
      steady = (p == 2 || p == 5);
      repeat (200) send_angle(random_angle());
      wait_idle();
    end
    steady = 1'b0;
  endtask

  // Takes each result after a random stall (none in steady phases) and checks it against the oldest prediction.
  initial begin : result_sink
    int stall;
    bit seen;
    logic signed [SINE_W-1:0] got_sine;
    logic got_clamped;
    sine_result_t want;
    wait (rst_n);
    @(posedge clk);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do begin
        @(negedge clk);
        seen = out_valid;
        got_sine = out_sine;
        got_clamped = out_clamped;
        @(posedge clk);
      end while (!seen);
      if (pending_sines.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: sine=%0d clamped=%0b", got_sine, got_clamped);
      end else begin
        want = pending_sines.pop_front();
        if (got_sine !== want.sine || got_clamped !== want.clamped) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected sine=%0d clamped=%0b, got sine=%0d clamped=%0b",
                     want.sine, want.clamped, got_sine, got_clamped);
        end
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_term_sweep();
    test_random_phases();
    wait_idle();
    if (mismatches == 0 && pending_sines.size() == 0) begin
      $display("tb_sine_series_unit: PASS");
    end else begin
      $display("tb_sine_series_unit: FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
src/ssu_pkg.sv
src/ssu_term_step.sv
src/sine_series_unit.sv
tb/tb_sine_series_unit.sv
